// ===== src/tcg_pkg.sv =====
// Shared types, codes and font table for the text cursor glyph renderer.
package tcg_pkg;

	localparam int COL_W = 5;
	localparam int ROW_W = 4;
	localparam int CHARS_PER_LINE_DEF = 22;
	localparam int LINES_PER_SCREEN_DEF = 16;

	localparam int GLYPH_COLS = 5;
	localparam int CELL_W = 6;
	localparam int CELL_H = 8;
	localparam int Y_OFFSET = 2;
	localparam int FONT_DEPTH = 640;
	localparam int FONT_AW = 10;

	localparam logic [2:0] LAST_COL = 3'(CELL_W - 1);
	localparam logic [2:0] LAST_ROW = 3'(CELL_H - 1);

	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_GOTO = 1'b1;
	localparam logic [7:0] CODE_LF = 8'd10;
	localparam logic [7:0] CODE_CR = 8'd13;

	typedef enum logic [1:0] {
		REG_FORE_COLOR = 2'd0,
		REG_BACK_COLOR = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic       func;
		logic [7:0] char_code;
		logic [7:0] goto_column;
		logic [7:0] goto_row;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic [7:0] pixel_color;
		logic       last_pixel;
	} out_item_t;

	// cell job handed from cursor logic to the rasterizer
	typedef struct packed {
		logic [7:0] code;
		logic [7:0] x0;
		logic [7:0] y0;
	} job_t;

	localparam logic [0:FONT_DEPTH-1][7:0] FONT = {
		8'h00,8'h00,8'h00,8'h00,8'h00, 8'h3E,8'h0A,8'h34,8'h00,8'h3E,
		8'h18,8'h3E,8'h00,8'h3E,8'h22, 8'h00,8'h3E,8'h20,8'h20,8'h00,
		8'h22,8'h1C,8'h00,8'h24,8'h2A, 8'h00,8'h08,8'h38,8'h38,8'h08,
		8'h1C,8'h22,8'h22,8'h22,8'h1C, 8'h00,8'h38,8'h38,8'h44,8'h82,
		8'h1C,8'h3E,8'h62,8'h62,8'h32, 8'h2E,8'h26,8'h23,8'h23,8'h22,
		8'h00,8'h00,8'h00,8'h00,8'h00, 8'h1C,8'h3E,8'h36,8'h22,8'h36,
		8'h3E,8'h3E,8'h36,8'h36,8'h36, 8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h18,8'h08,8'h1C,8'h22,8'h22, 8'h63,8'h55,8'h4D,8'h55,8'h6B,
		8'h00,8'h3E,8'h0A,8'h04,8'h78, 8'h00,8'h3E,8'h0A,8'h04,8'h78,
		8'h00,8'h38,8'h44,8'h5F,8'h4E, 8'h00,8'h38,8'h44,8'h44,8'h5F,
		8'h00,8'h3C,8'h3C,8'h3C,8'h3C, 8'h00,8'h3E,8'h0A,8'h04,8'h78,
		8'h00,8'h3E,8'h0A,8'h04,8'h78, 8'h44,8'h40,8'h38,8'h00,8'h04,
		8'h00,8'h7F,8'h3E,8'h1C,8'h08, 8'h08,8'h08,8'h2A,8'h1C,8'h08,
		8'h08,8'h1C,8'h2A,8'h08,8'h08, 8'h08,8'h08,8'h2A,8'h08,8'h08,
		8'h00,8'h3C,8'h20,8'h00,8'h00, 8'h08,8'h14,8'h00,8'h14,8'h08,
		8'h08,8'h0C,8'h0E,8'h0C,8'h08, 8'h08,8'h18,8'h38,8'h18,8'h08,
		8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
		8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
		8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
		8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
		8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
		8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
		8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
		8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
		8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
		8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
		8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
		8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
		8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
		8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
		8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
		8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06,
		8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
		8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
		8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
		8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h3E,8'h41,8'h49,8'h49,8'h7A,
		8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
		8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
		8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h0C,8'h02,8'h7F,
		8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
		8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
		8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
		8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
		8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h38,8'h40,8'h3F,
		8'h63,8'h14,8'h08,8'h14,8'h63, 8'h07,8'h08,8'h70,8'h08,8'h07,
		8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h7F,8'h41,8'h41,8'h00,
		8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7F,8'h00,
		8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
		8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
		8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20,
		8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18,
		8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h0C,8'h52,8'h52,8'h52,8'h3E,
		8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00,
		8'h20,8'h40,8'h44,8'h3D,8'h00, 8'h7F,8'h10,8'h28,8'h44,8'h00,
		8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
		8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
		8'h7C,8'h14,8'h14,8'h14,8'h08, 8'h08,8'h14,8'h14,8'h18,8'h7C,
		8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
		8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C,
		8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h40,8'h30,8'h40,8'h3C,
		8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
		8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h00,8'h36,8'h41,8'h00,
		8'h00,8'h00,8'h7F,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,
		8'h10,8'h08,8'h08,8'h10,8'h08, 8'h78,8'h46,8'h41,8'h46,8'h78
	};

endpackage

// ===== src/text_cursor_glyph_renderer.sv =====
// Top level of the text cursor glyph renderer: color registers, cursor and rasterizer.
// Printable char: the cell enters stage 1 and its first pixel is registered in stage 2;
//   then one pixel per cycle unless stalled; 48 per cell, one ROM byte per pixel counter step.
// Newline, carriage return and goto give no pixels; every request is taken once the rasterizer
//   can load a new cell (at the 48th pixel of the current one).
// Reset (arst_n low, async): cursor at column 0 row 0, fore 255, back 0, pipeline empty.
module text_cursor_glyph_renderer #(
	parameter int CHARS_PER_LINE   = tcg_pkg::CHARS_PER_LINE_DEF,
	parameter int LINES_PER_SCREEN = tcg_pkg::LINES_PER_SCREEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tcg_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tcg_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	logic [7:0]    fore_q, back_q;
	logic          job_valid, job_ready;
	tcg_pkg::job_t job;

	// Color registers; to be written only while idle, so no hazard with pixels in flight; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q <= 8'hFF;
			back_q <= 8'h00;
		end else if (cfg_we) begin
			case (cfg_index)
				tcg_pkg::REG_FORE_COLOR: fore_q <= cfg_data;
				tcg_pkg::REG_BACK_COLOR: back_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A request of any kind waits while the rasterizer holds a cell it cannot retire,
	// which keeps cursor updates in order with the cells drawn.
	assign in_stall = !job_ready;

	tcg_cursor #(
		.CHARS_PER_LINE   (CHARS_PER_LINE),
		.LINES_PER_SCREEN (LINES_PER_SCREEN)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.job_ready (job_ready),
		.job_valid (job_valid),
		.job       (job)
	);

	// Two-stage walk: counter/ROM address, then pixel register with ROM data.
	tcg_raster u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.job_ready  (job_ready),
		.fore_color (fore_q),
		.back_color (back_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ===== src/tcg_font_rom.sv =====
// Synchronous font ROM, one glyph column byte per read, output registered.
module tcg_font_rom (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tcg_pkg::FONT_AW-1:0] addr,
	output logic [7:0]                  dout
);

	logic [7:0] dout_q;

	// spacing column addresses may run one past the table end
	always_ff @(posedge clk) begin
		if (en) begin
			if (addr < tcg_pkg::FONT_AW'(tcg_pkg::FONT_DEPTH)) begin
				dout_q <= tcg_pkg::FONT[addr];
			end else begin
				dout_q <= 8'h00;
			end
		end
	end

	assign dout = dout_q;

endmodule

// ===== src/tcg_cursor.sv =====
// Cursor column/row tracking and cell job generation.
module tcg_cursor #(
	parameter int CHARS_PER_LINE   = tcg_pkg::CHARS_PER_LINE_DEF,
	parameter int LINES_PER_SCREEN = tcg_pkg::LINES_PER_SCREEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tcg_pkg::in_item_t in_data,
	input  logic              job_ready,
	output logic              job_valid,
	output tcg_pkg::job_t     job
);

	localparam logic [7:0] MAX_COL = 8'(CHARS_PER_LINE - 1);
	localparam logic [7:0] MAX_ROW = 8'(LINES_PER_SCREEN - 1);

	logic [tcg_pkg::COL_W-1:0] col_q;
	logic [tcg_pkg::ROW_W-1:0] row_q;
	logic [tcg_pkg::COL_W-1:0] col_d, draw_col;
	logic [tcg_pkg::ROW_W-1:0] row_d, draw_row, lf_row, row_inc;
	logic                      printable, accept;

	// row + 1 wraps in 4 bits, then wraps to 0 at the screen height
	always_comb begin
		row_inc = row_q + 1'b1;
		if ({1'b0, row_inc} >= (tcg_pkg::ROW_W + 1)'(LINES_PER_SCREEN)) begin
			lf_row = '0;
		end else begin
			lf_row = row_inc;
		end
	end

	assign printable = (in_data.func == tcg_pkg::FUNC_PUT) &&
		(in_data.char_code != tcg_pkg::CODE_LF) &&
		(in_data.char_code != tcg_pkg::CODE_CR);
	assign accept    = in_valid && job_ready;
	assign job_valid = in_valid && printable;

	always_comb begin
		// full line wraps before drawing
		if (col_q >= tcg_pkg::COL_W'(CHARS_PER_LINE)) begin
			draw_col = '0;
			draw_row = lf_row;
		end else begin
			draw_col = col_q;
			draw_row = row_q;
		end

		col_d = col_q;
		row_d = row_q;
		if (in_data.func == tcg_pkg::FUNC_GOTO) begin
			col_d = (in_data.goto_column > MAX_COL) ? '0 : in_data.goto_column[tcg_pkg::COL_W-1:0];
			row_d = (in_data.goto_row > MAX_ROW) ? '0 : in_data.goto_row[tcg_pkg::ROW_W-1:0];
		end else if (in_data.char_code == tcg_pkg::CODE_LF) begin
			col_d = '0;
			row_d = lf_row;
		end else if (in_data.char_code == tcg_pkg::CODE_CR) begin
			col_d = '0;
		end else begin
			col_d = draw_col + 1'b1;
			row_d = draw_row;
		end
	end

	// x0 = 6*col, y0 = 8*row + 2
	assign job.code = in_data.char_code;
	assign job.x0   = 8'({draw_col, 2'b00}) + 8'({draw_col, 1'b0});
	assign job.y0   = 8'({draw_row, 3'b000}) + 8'(tcg_pkg::Y_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

// ===== src/tcg_raster.sv =====
// Cell rasterizer: walks 48 pixels, reads the font ROM, registers each pixel.
module tcg_raster (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  tcg_pkg::job_t      job,
	output logic               job_ready,
	input  logic [7:0]         fore_color,
	input  logic [7:0]         back_color,
	output logic               out_valid,
	input  logic               out_stall,
	output tcg_pkg::out_item_t out_data
);

	// stage 1: pixel counter and ROM address
	logic          valid_s1;
	tcg_pkg::job_t job_s1;
	logic [2:0]    k_s1, i_s1;
	// stage 2: pixel register, ROM data alongside
	logic          valid_s2;
	logic [7:0]    x_s2, y_s2;
	logic [2:0]    k_s2;
	logic          draw_s2, last_s2;

	logic                        adv, last1;
	logic [tcg_pkg::FONT_AW-1:0] rom_addr, code_ext;
	logic [7:0]                  rom_data;

	assign adv       = !valid_s2 || !out_stall;
	assign last1     = (k_s1 == tcg_pkg::LAST_ROW) && (i_s1 == tcg_pkg::LAST_COL);
	assign job_ready = !valid_s1 || (adv && last1);

	assign code_ext = tcg_pkg::FONT_AW'(job_s1.code[6:0]);
	assign rom_addr = (code_ext << 2) + code_ext + tcg_pkg::FONT_AW'(i_s1);

	tcg_font_rom u_rom (
		.clk  (clk),
		.en   (adv),
		.addr (rom_addr),
		.dout (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (job_ready) begin
			valid_s1 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready) begin
			job_s1 <= job;
			k_s1   <= '0;
			i_s1   <= '0;
		end else if (adv) begin
			if (i_s1 == tcg_pkg::LAST_COL) begin
				i_s1 <= '0;
				k_s1 <= k_s1 + 1'b1;
			end else begin
				i_s1 <= i_s1 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2    <= job_s1.x0 + 8'(i_s1);
			y_s2    <= job_s1.y0 + 8'(k_s1);
			k_s2    <= k_s1;
			draw_s2 <= !job_s1.code[7] && (i_s1 != tcg_pkg::LAST_COL);
			last_s2 <= last1;
		end
	end

	assign out_valid            = valid_s2;
	assign out_data.pixel_x     = x_s2;
	assign out_data.pixel_y     = y_s2;
	assign out_data.pixel_color = (draw_s2 && rom_data[k_s2]) ? fore_color : back_color;
	assign out_data.last_pixel  = last_s2;

endmodule

// ===== src/tcg_checker.sv =====
// Port-level checks for the text cursor glyph renderer, bound to the top level.
module tcg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input tcg_pkg::out_item_t out_data
);

	logic out_acc;
	assign out_acc = out_valid && !out_stall;

	// stalled pixel request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled pixel changed");

	// a cell streams without gaps until its last pixel
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !out_data.last_pixel |=> out_valid)
		else $error("gap inside a cell");

	// next pixel is one step right, or the start of the next pixel row
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !out_data.last_pixel |=>
		((out_data.pixel_y == $past(out_data.pixel_y)) &&
		 (out_data.pixel_x == 8'($past(out_data.pixel_x) + 8'd1))) ||
		((out_data.pixel_y == 8'($past(out_data.pixel_y) + 8'd1)) &&
		 (out_data.pixel_x == 8'($past(out_data.pixel_x) - 8'd5))))
		else $error("pixel order broken");

endmodule

bind text_cursor_glyph_renderer tcg_checker u_tcg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
